@@ sv/fgtr_pkg.sv @@
// fgtr_pkg: shared types, constants and the 5x5 glyph table for the text rasteriser
// used by fgtr_seq, fgtr_datapath and font_glyph_text_rasterizer; no dependencies
package fgtr_pkg;

    // defaults for the top-level parameters
    localparam int FGTR_SCREEN_WIDTH = 320;
    localparam int FGTR_MAX_SCALE    = 8;

    // fixed font geometry
    localparam int FGTR_GLYPH_COUNT  = 95;
    localparam int FGTR_FIRST_CODE   = 32;
    localparam int FGTR_LAST_CODE    = 126;
    localparam int FGTR_ADVANCE      = 6;
    localparam int FGTR_RIGHT_MARGIN = 10;
    localparam int FGTR_COLS         = 5;
    localparam int FGTR_ROWS         = 8;
    localparam int FGTR_ROM_ROWS     = 5;

    // configuration register indexes
    localparam logic [1:0] CFG_FG_COLOR = 2'd0;
    localparam logic [1:0] CFG_BG_COLOR = 2'd1;
    localparam logic [1:0] CFG_SCALE    = 2'd2;

    // reset values of the configuration registers
    localparam logic [15:0] FG_COLOR_RESET = 16'hFFFF;
    localparam logic [15:0] BG_COLOR_RESET = 16'h0000;
    localparam logic [3:0]  SCALE_RESET    = 4'd1;

    // input transfer payload
    typedef struct packed {
        logic               new_string;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [7:0]         char_code;
    } fgtr_in_t;

    // result transfer payload
    typedef struct packed {
        logic signed [15:0] cell_x;
        logic signed [15:0] cell_y;
        logic [15:0]        pixel_color;
        logic               last;
    } fgtr_out_t;

    // strobes from the sequencer to the datapath
    typedef struct packed {
        logic load;       // input transfer: latch character, maybe load origin
        logic cell_step;  // result transfer: move to the next cell
        logic advance;    // move the cursor and apply the halt test
    } fgtr_ctrl_t;

    // flags from the datapath for conditional jumps
    typedef struct packed {
        logic halted;
        logic noprint;
        logic last_cell;
    } fgtr_status_t;

    // five rows of five bits, top row in the upper bits, bit 4 of a row is leftmost
    typedef logic [24:0] fgtr_glyph_t;

    function automatic fgtr_glyph_t fgtr_glyph(input logic [6:0] idx);
        fgtr_glyph_t g;
        case (idx)
            7'd0:  g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
            7'd1:  g = {5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
            7'd2:  g = {5'h0A, 5'h0A, 5'h00, 5'h00, 5'h00};
            7'd3:  g = {5'h0A, 5'h1F, 5'h0A, 5'h1F, 5'h0A};
            7'd4:  g = {5'h0E, 5'h14, 5'h0E, 5'h05, 5'h0E};
            7'd5:  g = {5'h11, 5'h09, 5'h04, 5'h12, 5'h11};
            7'd6:  g = {5'h0C, 5'h12, 5'h0C, 5'h12, 5'h0D};
            7'd7:  g = {5'h04, 5'h04, 5'h00, 5'h00, 5'h00};
            7'd8:  g = {5'h02, 5'h04, 5'h04, 5'h04, 5'h02};
            7'd9:  g = {5'h08, 5'h04, 5'h04, 5'h04, 5'h08};
            7'd10: g = {5'h04, 5'h15, 5'h0E, 5'h15, 5'h04};
            7'd11: g = {5'h04, 5'h04, 5'h0E, 5'h04, 5'h04};
            7'd12: g = {5'h00, 5'h00, 5'h00, 5'h04, 5'h08};
            7'd13: g = {5'h00, 5'h00, 5'h0E, 5'h00, 5'h00};
            7'd14: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
            7'd15: g = {5'h01, 5'h02, 5'h04, 5'h08, 5'h10};
            7'd16: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h0E};
            7'd17: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h0E};
            7'd18: g = {5'h0E, 5'h11, 5'h02, 5'h04, 5'h1F};
            7'd19: g = {5'h0E, 5'h11, 5'h06, 5'h11, 5'h0E};
            7'd20: g = {5'h08, 5'h0C, 5'h0A, 5'h1F, 5'h08};
            7'd21: g = {5'h1F, 5'h10, 5'h0E, 5'h01, 5'h0E};
            7'd22: g = {5'h06, 5'h08, 5'h0E, 5'h11, 5'h0E};
            7'd23: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08};
            7'd24: g = {5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E};
            7'd25: g = {5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0C};
            7'd26: g = {5'h00, 5'h04, 5'h00, 5'h04, 5'h00};
            7'd27: g = {5'h00, 5'h04, 5'h00, 5'h04, 5'h08};
            7'd28: g = {5'h02, 5'h04, 5'h08, 5'h04, 5'h02};
            7'd29: g = {5'h00, 5'h0E, 5'h00, 5'h0E, 5'h00};
            7'd30: g = {5'h08, 5'h04, 5'h02, 5'h04, 5'h08};
            7'd31: g = {5'h0E, 5'h11, 5'h02, 5'h00, 5'h02};
            7'd32: g = {5'h0E, 5'h15, 5'h17, 5'h10, 5'h0E};
            7'd33: g = {5'h0E, 5'h11, 5'h1F, 5'h11, 5'h11};
            7'd34: g = {5'h1E, 5'h11, 5'h1E, 5'h11, 5'h1E};
            7'd35: g = {5'h0E, 5'h10, 5'h10, 5'h10, 5'h0E};
            7'd36: g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E};
            7'd37: g = {5'h1F, 5'h10, 5'h1E, 5'h10, 5'h1F};
            7'd38: g = {5'h1F, 5'h10, 5'h1E, 5'h10, 5'h10};
            7'd39: g = {5'h0E, 5'h10, 5'h13, 5'h11, 5'h0E};
            7'd40: g = {5'h11, 5'h11, 5'h1F, 5'h11, 5'h11};
            7'd41: g = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h0E};
            7'd42: g = {5'h07, 5'h02, 5'h02, 5'h12, 5'h0C};
            7'd43: g = {5'h11, 5'h12, 5'h1C, 5'h12, 5'h11};
            7'd44: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            7'd45: g = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11};
            7'd46: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11};
            7'd47: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
            7'd48: g = {5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
            7'd49: g = {5'h0E, 5'h11, 5'h11, 5'h12, 5'h0D};
            7'd50: g = {5'h1E, 5'h11, 5'h1E, 5'h12, 5'h11};
            7'd51: g = {5'h0E, 5'h10, 5'h0E, 5'h01, 5'h0E};
            7'd52: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04};
            7'd53: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            7'd54: g = {5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04};
            7'd55: g = {5'h11, 5'h11, 5'h15, 5'h1B, 5'h11};
            7'd56: g = {5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
            7'd57: g = {5'h11, 5'h0A, 5'h04, 5'h04, 5'h04};
            7'd58: g = {5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
            7'd59: g = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h0E};
            7'd60: g = {5'h10, 5'h08, 5'h04, 5'h02, 5'h01};
            7'd61: g = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h0E};
            7'd62: g = {5'h04, 5'h0A, 5'h11, 5'h00, 5'h00};
            7'd63: g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
            7'd64: g = {5'h08, 5'h04, 5'h02, 5'h00, 5'h00};
            7'd65: g = {5'h00, 5'h0E, 5'h01, 5'h0F, 5'h0E};
            7'd66: g = {5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            7'd67: g = {5'h00, 5'h0E, 5'h10, 5'h10, 5'h0E};
            7'd68: g = {5'h01, 5'h0F, 5'h11, 5'h11, 5'h0E};
            7'd69: g = {5'h00, 5'h0E, 5'h1F, 5'h10, 5'h0E};
            7'd70: g = {5'h06, 5'h08, 5'h0E, 5'h08, 5'h08};
            7'd71: g = {5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E};
            7'd72: g = {5'h10, 5'h1E, 5'h11, 5'h11, 5'h11};
            7'd73: g = {5'h04, 5'h00, 5'h04, 5'h04, 5'h04};
            7'd74: g = {5'h02, 5'h00, 5'h02, 5'h02, 5'h0C};
            7'd75: g = {5'h10, 5'h12, 5'h0C, 5'h12, 5'h11};
            7'd76: g = {5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
            7'd77: g = {5'h00, 5'h1A, 5'h15, 5'h15, 5'h11};
            7'd78: g = {5'h00, 5'h1E, 5'h11, 5'h11, 5'h11};
            7'd79: g = {5'h00, 5'h0E, 5'h11, 5'h11, 5'h0E};
            7'd80: g = {5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
            7'd81: g = {5'h0F, 5'h11, 5'h0F, 5'h01, 5'h01};
            7'd82: g = {5'h00, 5'h1E, 5'h10, 5'h10, 5'h10};
            7'd83: g = {5'h00, 5'h0E, 5'h10, 5'h01, 5'h0E};
            7'd84: g = {5'h08, 5'h0E, 5'h08, 5'h08, 5'h06};
            7'd85: g = {5'h00, 5'h11, 5'h11, 5'h11, 5'h0E};
            7'd86: g = {5'h00, 5'h11, 5'h0A, 5'h0A, 5'h04};
            7'd87: g = {5'h00, 5'h11, 5'h15, 5'h1B, 5'h11};
            7'd88: g = {5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A};
            7'd89: g = {5'h11, 5'h0A, 5'h04, 5'h08, 5'h10};
            7'd90: g = {5'h00, 5'h1F, 5'h04, 5'h08, 5'h1F};
            7'd91: g = {5'h06, 5'h04, 5'h08, 5'h04, 5'h06};
            7'd92: g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            7'd93: g = {5'h0C, 5'h04, 5'h02, 5'h04, 5'h0C};
            7'd94: g = {5'h08, 5'h15, 5'h02, 5'h00, 5'h00};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

@@ sv/fgtr_seq.sv @@
// fgtr_seq: microcoded sequencer, step counter plus a read-only control-word table
// depends on fgtr_pkg for the control and status structs
module fgtr_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  fgtr_pkg::fgtr_status_t status,
    output fgtr_pkg::fgtr_ctrl_t   ctrl
);
    import fgtr_pkg::*;

    // step codes
    localparam logic [2:0] STEP_WAIT  = 3'd0;
    localparam logic [2:0] STEP_HALT  = 3'd1;
    localparam logic [2:0] STEP_PRINT = 3'd2;
    localparam logic [2:0] STEP_EMIT  = 3'd3;
    localparam logic [2:0] STEP_ADV   = 3'd4;

    // jump conditions
    localparam logic [2:0] COND_ALWAYS   = 3'd0;
    localparam logic [2:0] COND_ACCEPT   = 3'd1;
    localparam logic [2:0] COND_HALTED   = 3'd2;
    localparam logic [2:0] COND_NOPRINT  = 3'd3;
    localparam logic [2:0] COND_CELLDONE = 3'd4;

    typedef struct packed {
        logic       in_ready;
        logic       out_valid;
        logic       advance;
        logic       hold;     // stay on this step when the condition is false
        logic [2:0] cond;
        logic [2:0] target;
    } uword_t;

    // microprogram; unused steps fall back to waiting
    localparam uword_t UCODE [0:7] = '{
        '{1'b1, 1'b0, 1'b0, 1'b1, COND_ACCEPT,   STEP_HALT},
        '{1'b0, 1'b0, 1'b0, 1'b0, COND_HALTED,   STEP_WAIT},
        '{1'b0, 1'b0, 1'b0, 1'b0, COND_NOPRINT,  STEP_ADV},
        '{1'b0, 1'b1, 1'b0, 1'b1, COND_CELLDONE, STEP_ADV},
        '{1'b0, 1'b0, 1'b1, 1'b0, COND_ALWAYS,   STEP_WAIT},
        '{1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS,   STEP_WAIT},
        '{1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS,   STEP_WAIT},
        '{1'b0, 1'b0, 1'b0, 1'b0, COND_ALWAYS,   STEP_WAIT}
    };

    logic [2:0] step_reg;
    logic [2:0] step_next;
    uword_t     uw;
    logic       cond_true;

    assign uw = UCODE[step_reg];

    // condition select
    always_comb begin
        unique case (uw.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_ACCEPT:   cond_true = s_valid;
            COND_HALTED:   cond_true = status.halted;
            COND_NOPRINT:  cond_true = status.noprint;
            COND_CELLDONE: cond_true = m_ready && status.last_cell;
            default:       cond_true = 1'b1;
        endcase
    end

    // next step: jump, hold or fall through
    always_comb begin
        if (cond_true) begin
            step_next = uw.target;
        end else if (uw.hold) begin
            step_next = step_reg;
        end else begin
            step_next = step_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

    // handshakes and datapath strobes
    assign s_ready        = uw.in_ready;
    assign m_valid        = uw.out_valid;
    assign ctrl.load      = uw.in_ready && s_valid;
    assign ctrl.cell_step = uw.out_valid && m_ready;
    assign ctrl.advance   = uw.advance;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result channels open together");
    a_accept_test: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (step_reg == STEP_HALT))
        else $error("input transfer not followed by halt test");
    a_done_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && status.last_cell) |=> (step_reg == STEP_ADV))
        else $error("last cell transfer not followed by cursor advance");
    a_adv_once: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.advance |=> (step_reg == STEP_WAIT))
        else $error("cursor advance not followed by wait");
`endif

endmodule

@@ sv/fgtr_datapath.sv @@
// fgtr_datapath: configuration registers, cursor, halt flag and the cell walk
// depends on fgtr_pkg for payload structs, glyph table and constants
module fgtr_datapath #(
    parameter int SCREEN_WIDTH = fgtr_pkg::FGTR_SCREEN_WIDTH,
    parameter int MAX_SCALE    = fgtr_pkg::FGTR_MAX_SCALE
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_wdata,
    input  fgtr_pkg::fgtr_in_t     s_data,
    output fgtr_pkg::fgtr_out_t    m_data,
    input  fgtr_pkg::fgtr_ctrl_t   ctrl,
    output fgtr_pkg::fgtr_status_t status
);
    import fgtr_pkg::*;

    localparam int SCALE_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE + 1) : 1;
    localparam logic signed [15:0] HALT_LIMIT = 16'(SCREEN_WIDTH - FGTR_RIGHT_MARGIN);
    localparam logic [2:0] LAST_COL = 3'(FGTR_COLS - 1);
    localparam logic [2:0] LAST_ROW = 3'(FGTR_ROWS - 1);
    localparam logic [2:0] ROM_LAST = 3'(FGTR_ROM_ROWS - 1);

    logic [15:0]        fg_color_reg;
    logic [15:0]        bg_color_reg;
    logic [3:0]         scale_reg;
    logic [15:0]        cursor_reg;
    logic [15:0]        line_reg;
    logic               halted_reg;
    logic               noprint_reg;
    fgtr_glyph_t        glyph_reg;
    logic [SCALE_W-1:0] s_reg;
    logic [2:0]         row_reg;
    logic [2:0]         col_reg;
    logic [15:0]        x_reg;
    logic [15:0]        y_reg;

    logic [SCALE_W-1:0] s_eff;
    logic [15:0]        cursor_load;
    logic [15:0]        cursor_next;
    logic [6:0]         glyph_idx;
    logic               printable;
    logic [2:0]         row_c;
    logic [4:0]         bit_idx;
    logic               last_cell;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_color_reg <= FG_COLOR_RESET;
            bg_color_reg <= BG_COLOR_RESET;
            scale_reg    <= SCALE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FG_COLOR: fg_color_reg <= cfg_wdata;
                CFG_BG_COLOR: bg_color_reg <= cfg_wdata;
                CFG_SCALE:    scale_reg    <= cfg_wdata[3:0];
                default:      ;
            endcase
        end
    end

    // scale of zero reads as one, large scales saturate
    always_comb begin
        if (scale_reg == 4'd0) begin
            s_eff = SCALE_W'(1);
        end else if (int'(scale_reg) > MAX_SCALE) begin
            s_eff = SCALE_W'(MAX_SCALE);
        end else begin
            s_eff = SCALE_W'(scale_reg);
        end
    end

    // character decode at input transfer
    assign printable   = (s_data.char_code >= 8'(FGTR_FIRST_CODE)) &&
                         (s_data.char_code <= 8'(FGTR_LAST_CODE));
    assign glyph_idx   = 7'(s_data.char_code - 8'(FGTR_FIRST_CODE));
    assign cursor_load = s_data.new_string ? s_data.start_x : cursor_reg;
    assign cursor_next = cursor_reg + 16'(16'(s_reg) * 16'(FGTR_ADVANCE));

    // cursor, line origin and halt flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
            line_reg   <= '0;
            halted_reg <= 1'b0;
        end else if (ctrl.load) begin
            if (s_data.new_string) begin
                cursor_reg <= s_data.start_x;
                line_reg   <= s_data.start_y;
                halted_reg <= 1'b0;
            end
        end else if (ctrl.advance) begin
            cursor_reg <= cursor_next;
            halted_reg <= ($signed(cursor_next) >= HALT_LIMIT);
        end
    end

    // per-character latches and the row-major cell walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (ctrl.load) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (ctrl.cell_step) begin
            if (col_reg == LAST_COL) begin
                col_reg <= '0;
                row_reg <= row_reg + 3'd1;
            end else begin
                col_reg <= col_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            noprint_reg <= !printable;
            glyph_reg   <= fgtr_glyph(glyph_idx);
            s_reg       <= s_eff;
            x_reg       <= cursor_load;
            y_reg       <= s_data.new_string ? s_data.start_y : line_reg;
        end else if (ctrl.cell_step) begin
            if (col_reg == LAST_COL) begin
                x_reg <= cursor_reg;
                y_reg <= y_reg + 16'(s_reg);
            end else begin
                x_reg <= x_reg + 16'(s_reg);
            end
        end
    end

    // rows below the fifth repeat the fifth
    assign row_c     = (row_reg > ROM_LAST) ? ROM_LAST : row_reg;
    assign bit_idx   = 5'(5'd24 - 5'(row_c) * 5'd5 - 5'(col_reg));
    assign last_cell = (row_reg == LAST_ROW) && (col_reg == LAST_COL);

    // result payload
    assign m_data.cell_x      = x_reg;
    assign m_data.cell_y      = y_reg;
    assign m_data.pixel_color = glyph_reg[bit_idx] ? fg_color_reg : bg_color_reg;
    assign m_data.last        = last_cell;

    assign status.halted    = halted_reg;
    assign status.noprint   = noprint_reg;
    assign status.last_cell = last_cell;

endmodule

@@ sv/font_glyph_text_rasterizer.sv @@
// sequence: an input transfer is followed by the halt test step and the print test step,
// then the first cell is offered
// per character: printable 40 cells at one per cycle while m_ready is high, plus 4 control
// steps; non-printable only the 4 control steps; halted only the wait and halt test steps
// the microprogram step counter sets this: one step per cycle unless a step holds, the cell step repeats
// reset: synchronous, clears cursor, line origin, halt flag and step counter,
// colours to white on black and scale to one
module font_glyph_text_rasterizer #(
    parameter int SCREEN_WIDTH = fgtr_pkg::FGTR_SCREEN_WIDTH,
    parameter int MAX_SCALE    = fgtr_pkg::FGTR_MAX_SCALE
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  fgtr_pkg::fgtr_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fgtr_pkg::fgtr_out_t m_data
);
    import fgtr_pkg::*;

    fgtr_ctrl_t   ctrl;
    fgtr_status_t status;

    // control sequencer
    fgtr_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    // cursor and cell datapath
    fgtr_datapath #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .MAX_SCALE    (MAX_SCALE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .ctrl      (ctrl),
        .status    (status)
    );

endmodule
